FILE: rtl/core/opd_pkg.sv
// Shared constants and register indexes for the optical preamble detector.
`default_nettype none

package opd_pkg;

  localparam int DECAY_W    = 8;
  localparam int TOL_W      = 13;
  localparam int INTERVAL_W = 15;
  localparam int TIME_W     = 32;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 15;
  localparam int RING_DEPTH = 4;
  localparam int RING_PTR_W = 2;

  // Full-scale filter weight: old and new weights add up to this.
  localparam logic [DECAY_W:0] WEIGHT_ONE = 9'd256;

  localparam logic [INTERVAL_W-1:0] INTERVAL_SAT = 15'h7fff;

  localparam logic [CFG_ADDR_W-1:0] REG_DECAY_WEIGHT = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TOLERANCE    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_INTERVAL = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_INTERVAL = 2'd3;

  localparam logic [DECAY_W-1:0]    DECAY_RESET = 8'd192;
  localparam logic [TOL_W-1:0]      TOL_RESET   = 13'd10;
  localparam logic [INTERVAL_W-1:0] MIN_RESET   = 15'd50;
  localparam logic [INTERVAL_W-1:0] MAX_RESET   = 15'd500;

endpackage

`default_nettype wire

FILE: rtl/core/opd_filter.sv
// First-order exponential smoothing of one ADC channel.
`default_nettype none

module opd_filter #(
  parameter int ADC_BITS = 10
) (
  input  logic [ADC_BITS-1:0]        smooth_i,
  input  logic [ADC_BITS-1:0]        sample_i,
  input  logic [opd_pkg::DECAY_W-1:0] weight_i,
  output logic [ADC_BITS-1:0]        smooth_o
);
  import opd_pkg::*;

  localparam int ProdW = ADC_BITS + DECAY_W + 1;

  logic [DECAY_W:0] inv_weight;
  logic [ProdW-1:0] old_term;
  logic [ProdW-1:0] new_term;
  logic [ProdW-1:0] total;

  always_comb begin
    inv_weight = WEIGHT_ONE - {1'b0, weight_i};
    old_term   = ProdW'(smooth_i) * ProdW'(weight_i);
    new_term   = ProdW'(sample_i) * ProdW'(inv_weight);
    // weights sum to 256, so the total never exceeds full scale << 8
    total      = old_term + new_term;
    smooth_o   = total[DECAY_W +: ADC_BITS];
  end

endmodule

`default_nettype wire

FILE: rtl/core/optical_preamble_detector_top.sv
// Top level of the optical preamble detector: input register, filters, interval ring.
//
// Usage: one word on the slave stream carries a pair of phototransistor ADC
// samples and a millisecond timestamp; the master stream returns one word for
// each, giving the phase, whether the phase flipped, the interval since the
// previous flip (zero when no flip) and the preamble flag.
// Settings are written through the plain write port (cfg_we_i, cfg_addr_i,
// cfg_wdata_i) while the stream is idle.
// Timing: an accepted word is captured in the input register, then worked through
// both filters and the ring update into the result register, which drives the
// master side; one word per cycle sustained while m_axis_tready_i is high. The rate
// is set by the filter state loop, which is combinational between its registers.
// Stalls: while m_axis_tready_i is low the result holds; the input register
// still takes one more word, then s_axis_tready_o drops until the result drains.
// Reset: filters, phase, preamble flag, ring, pointer and flip time clear to
// zero, settings return to their defaults, and both streams show no word.
`default_nettype none

module optical_preamble_detector_top #(
  parameter int ADC_BITS = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // sample_a, sample_b, time_ms, zero pad
  input  logic [((2*ADC_BITS+32+7)/8)*8-1:0] s_axis_tdata_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // phase_now, edge_seen, edge_interval, preamble_found, zero pad
  output logic [23:0]                       m_axis_tdata_o,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  input  logic                              cfg_we_i,
  input  logic [opd_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [opd_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);
  import opd_pkg::*;

  localparam int OutPayloadW = 3 + INTERVAL_W;

  // settings
  logic [DECAY_W-1:0]    decay_q;
  logic [TOL_W-1:0]      tol_q;
  logic [INTERVAL_W-1:0] min_q;
  logic [INTERVAL_W-1:0] max_q;

  // input register
  logic                in_valid_q;
  logic [ADC_BITS-1:0] in_a_q;
  logic [ADC_BITS-1:0] in_b_q;
  logic [TIME_W-1:0]   in_time_q;

  // detector state
  logic [ADC_BITS-1:0]   smooth_a_q, smooth_a_d;
  logic [ADC_BITS-1:0]   smooth_b_q, smooth_b_d;
  logic                  phase_q;
  logic                  preamble_q, preamble_d;
  logic [INTERVAL_W-1:0] ring_q [RING_DEPTH];
  logic [INTERVAL_W-1:0] ring_d [RING_DEPTH];
  logic [RING_PTR_W-1:0] ptr_q;
  logic [TIME_W-1:0]     flip_time_q;

  // result register
  logic                   out_valid_q;
  logic [OutPayloadW-1:0] out_data_q;

  logic                  fire;
  logic                  new_phase;
  logic                  flip;
  logic [TIME_W-1:0]     elapsed;
  logic [INTERVAL_W-1:0] interval;
  logic [INTERVAL_W-1:0] diff [RING_DEPTH];
  logic [INTERVAL_W+1:0] diff_sum;
  logic [INTERVAL_W-1:0] oldest;
  logic [RING_PTR_W-1:0] ptr_next;

  assign fire            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || fire;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(24 - OutPayloadW)'(0), out_data_q};

  opd_filter #(.ADC_BITS(ADC_BITS)) u_filter_a (
    .smooth_i (smooth_a_q),
    .sample_i (in_a_q),
    .weight_i (decay_q),
    .smooth_o (smooth_a_d)
  );

  opd_filter #(.ADC_BITS(ADC_BITS)) u_filter_b (
    .smooth_i (smooth_b_q),
    .sample_i (in_b_q),
    .weight_i (decay_q),
    .smooth_o (smooth_b_d)
  );

  always_comb begin
    new_phase = smooth_a_d < smooth_b_d;
    flip      = new_phase != phase_q;
    elapsed   = in_time_q - flip_time_q;
    interval  = (elapsed > TIME_W'(INTERVAL_SAT)) ? INTERVAL_SAT : elapsed[INTERVAL_W-1:0];
    ptr_next  = ptr_q + RING_PTR_W'(1);

    for (int i = 0; i < RING_DEPTH; i++) begin
      ring_d[i] = (ptr_q == RING_PTR_W'(i)) ? interval : ring_q[i];
    end

    // cyclic neighbour spread over the updated ring
    for (int i = 0; i < RING_DEPTH; i++) begin
      diff[i] = (ring_d[i] > ring_d[(i + 1) % RING_DEPTH])
              ? ring_d[i] - ring_d[(i + 1) % RING_DEPTH]
              : ring_d[(i + 1) % RING_DEPTH] - ring_d[i];
    end
    diff_sum = (INTERVAL_W+2)'(diff[0]) + (INTERVAL_W+2)'(diff[1])
             + (INTERVAL_W+2)'(diff[2]) + (INTERVAL_W+2)'(diff[3]);

    oldest     = ring_d[ptr_next];
    preamble_d = (oldest >= min_q) && (oldest <= max_q)
              && (diff_sum <= (INTERVAL_W+2)'({tol_q, 2'b00}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_q <= DECAY_RESET;
      tol_q   <= TOL_RESET;
      min_q   <= MIN_RESET;
      max_q   <= MAX_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_DECAY_WEIGHT: decay_q <= cfg_wdata_i[DECAY_W-1:0];
        REG_TOLERANCE:    tol_q   <= cfg_wdata_i[TOL_W-1:0];
        REG_MIN_INTERVAL: min_q   <= cfg_wdata_i[INTERVAL_W-1:0];
        REG_MAX_INTERVAL: max_q   <= cfg_wdata_i[INTERVAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_a_q    <= s_axis_tdata_i[ADC_BITS-1:0];
      in_b_q    <= s_axis_tdata_i[2*ADC_BITS-1:ADC_BITS];
      in_time_q <= s_axis_tdata_i[2*ADC_BITS +: TIME_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_a_q  <= '0;
      smooth_b_q  <= '0;
      phase_q     <= 1'b0;
      preamble_q  <= 1'b0;
      ptr_q       <= '0;
      flip_time_q <= '0;
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring_q[i] <= '0;
      end
    end else if (fire) begin
      smooth_a_q <= smooth_a_d;
      smooth_b_q <= smooth_b_d;
      if (flip) begin
        phase_q     <= new_phase;
        preamble_q  <= preamble_d;
        ptr_q       <= ptr_next;
        flip_time_q <= in_time_q;
        for (int i = 0; i < RING_DEPTH; i++) begin
          ring_q[i] <= ring_d[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= {flip ? preamble_d : preamble_q,
                     flip ? interval : INTERVAL_W'(0),
                     flip,
                     new_phase};
    end
  end

endmodule

`default_nettype wire
